// ===== design/meshb_pkg.sv =====
package meshb_pkg;

  localparam int VERT_W  = 12;
  localparam int SLOT_W  = 8;
  localparam int EPOCH_W = 8;

  localparam logic [7:0] VERTEX_LIMIT_RESET = 8'd64;
  localparam logic [7:0] INDEX_LIMIT_RESET  = 8'd126;
  localparam logic [7:0] TRI_INDICES        = 8'd3;

  localparam logic REG_VERTEX_LIMIT = 1'b0;
  localparam logic REG_INDEX_LIMIT  = 1'b1;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_CLOSE    = 2'd2
  } kind_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [VERT_W-1:0] va;
    logic [VERT_W-1:0] vb;
    logic [VERT_W-1:0] vc;
  } job_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [SLOT_W-1:0]  slot;
  } entry_t;

  typedef struct packed {
    kind_t             kind;
    logic [VERT_W-1:0] global_vertex;
    logic [7:0]        local_a;
    logic [7:0]        local_b;
    logic [7:0]        local_c;
    logic [7:0]        meshlet_vertices;
    logic [7:0]        meshlet_indices;
    logic              last;
  } result_t;

endpackage

// ===== design/meshb_ram.sv =====
module meshb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/meshb_front.sv =====
module meshb_front #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  meshb_pkg::cmd_t in_cmd,
  input  logic [11:0]     in_va,
  input  logic [11:0]     in_vb,
  input  logic [11:0]     in_vc,
  input  logic            init_busy,
  output meshb_pkg::job_t job,
  output logic            job_valid,
  input  logic            job_ready
);

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  meshb_pkg::job_t q [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  logic            accept;
  logic            push;
  logic            pop;
  logic            in_range;
  logic [AW+11:0]  ext_a;
  logic [AW+11:0]  ext_b;
  logic [AW+11:0]  ext_c;

  assign ext_a = {{AW{1'b0}}, in_va};
  assign ext_b = {{AW{1'b0}}, in_vb};
  assign ext_c = {{AW{1'b0}}, in_vc};

  assign in_range = (ext_a < (AW + 12)'(MAX_VERTICES)) &&
                    (ext_b < (AW + 12)'(MAX_VERTICES)) &&
                    (ext_c < (AW + 12)'(MAX_VERTICES));

  // A triangle that names a vertex outside the table is dropped here.
  assign in_ready  = (count != (PW + 1)'(DEPTH)) && !init_busy;
  assign accept    = in_valid && in_ready;
  assign push      = accept && ((in_cmd == meshb_pkg::CMD_FINISH) || in_range);
  assign job_valid = (count != '0);
  assign pop       = job_valid && job_ready;
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        q[wr_ptr] <= '{cmd: in_cmd, va: in_va, vb: in_vb, vc: in_vc};
        wr_ptr    <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/meshb_back.sv =====
module meshb_back #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  meshb_pkg::job_t    job,
  input  logic               job_valid,
  output logic               job_ready,
  input  logic [7:0]         vertex_limit,
  input  logic [7:0]         index_limit,
  output meshb_pkg::result_t res,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               init_busy
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int RW = $bits(meshb_pkg::entry_t);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RDB,
    S_RDC,
    S_EVAL,
    S_CLOSE,
    S_WIPE,
    S_VERT,
    S_TRI,
    S_FIN
  } state_t;

  state_t                          state;
  logic [AW-1:0]                   sweep_addr;
  logic                            wipe_resume;
  logic [meshb_pkg::EPOCH_W-1:0]   epoch;
  logic [7:0]                      vcount;
  logic [7:0]                      icount;
  logic [meshb_pkg::VERT_W-1:0]    cur_v [3];
  meshb_pkg::entry_t               ent_a;
  meshb_pkg::entry_t               ent_b;
  logic [2:0]                      used;
  logic [meshb_pkg::SLOT_W-1:0]    slot [3];
  logic [meshb_pkg::SLOT_W-1:0]    loc [3];
  logic [1:0]                      vi;

  meshb_pkg::entry_t               ent_c;
  logic [RW-1:0]                   rd_data;
  logic [AW-1:0]                   rd_addr;
  logic                            we;
  logic [AW-1:0]                   waddr;
  meshb_pkg::entry_t               wdata;
  logic                            can_emit;
  logic                            load_res;
  logic [2:0]                      hit;
  logic [1:0]                      need;
  logic [8:0]                      vsum;
  logic [8:0]                      isum;
  logic                            close_now;
  logic                            dup_hit;
  logic [meshb_pkg::SLOT_W-1:0]    dup_loc;
  logic                            is_new;
  logic                            step_ok;
  logic                            last_sweep;

  function automatic logic [AW-1:0] addr_of(input logic [meshb_pkg::VERT_W-1:0] v);
    logic [AW+meshb_pkg::VERT_W-1:0] ext;
    ext = {{AW{1'b0}}, v};
    return ext[AW-1:0];
  endfunction

  meshb_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_VERTICES)
  ) u_slot_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign ent_c      = rd_data;
  assign can_emit   = !res_valid || res_ready;
  assign job_ready  = (state == S_IDLE);
  assign init_busy  = (state == S_INIT);
  assign last_sweep = (sweep_addr == AW'(MAX_VERTICES - 1));

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = addr_of(job.va);
      S_RDB:   rd_addr = addr_of(cur_v[1]);
      S_RDC:   rd_addr = addr_of(cur_v[2]);
      default: rd_addr = addr_of(cur_v[0]);
    endcase
  end

  always_comb begin
    hit[0]    = (ent_a.epoch == epoch);
    hit[1]    = (ent_b.epoch == epoch);
    hit[2]    = (ent_c.epoch == epoch);
    need      = 2'({1'b0, !hit[0]} + {1'b0, !hit[1]} + {1'b0, !hit[2]});
    vsum      = {1'b0, vcount} + {7'd0, need};
    isum      = {1'b0, icount} + {1'b0, meshb_pkg::TRI_INDICES};
    close_now = ((vsum > {1'b0, vertex_limit}) || (isum > {1'b0, index_limit})) &&
                (icount != '0);
  end

  always_comb begin
    dup_hit = 1'b0;
    dup_loc = loc[0];
    case (vi)
      2'd1: begin
        dup_hit = (cur_v[1] == cur_v[0]);
      end
      2'd2: begin
        if (cur_v[2] == cur_v[0]) begin
          dup_hit = 1'b1;
        end else if (cur_v[2] == cur_v[1]) begin
          dup_hit = 1'b1;
          dup_loc = loc[1];
        end
      end
      default: begin
        dup_hit = 1'b0;
      end
    endcase
    is_new  = !used[vi] && !dup_hit;
    step_ok = !is_new || can_emit;
  end

  always_comb begin
    case (state)
      S_CLOSE, S_TRI: load_res = can_emit;
      S_VERT:         load_res = is_new && can_emit;
      S_FIN:          load_res = (icount != '0) && can_emit;
      default:        load_res = 1'b0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = sweep_addr;
    wdata = '0;
    case (state)
      S_INIT, S_WIPE: begin
        we = 1'b1;
      end
      S_VERT: begin
        we    = is_new && can_emit;
        waddr = addr_of(cur_v[vi]);
        wdata = '{epoch: epoch, slot: vcount};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      sweep_addr  <= '0;
      wipe_resume <= 1'b0;
      epoch       <= '0;
      vcount      <= '0;
      icount      <= '0;
      vi          <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (last_sweep) begin
            sweep_addr <= '0;
            epoch      <= meshb_pkg::EPOCH_W'(1);
            state      <= S_IDLE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        S_WIPE: begin
          if (last_sweep) begin
            sweep_addr <= '0;
            epoch      <= meshb_pkg::EPOCH_W'(1);
            state      <= wipe_resume ? S_VERT : S_IDLE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (job_valid) begin
            cur_v[0] <= job.va;
            cur_v[1] <= job.vb;
            cur_v[2] <= job.vc;
            state    <= (job.cmd == meshb_pkg::CMD_FINISH) ? S_FIN : S_RDB;
          end
        end
        S_RDB: begin
          ent_a <= rd_data;
          state <= S_RDC;
        end
        S_RDC: begin
          ent_b <= rd_data;
          state <= S_EVAL;
        end
        S_EVAL: begin
          used    <= hit & {3{!close_now}};
          slot[0] <= ent_a.slot;
          slot[1] <= ent_b.slot;
          slot[2] <= ent_c.slot;
          vi      <= '0;
          state   <= close_now ? S_CLOSE : S_VERT;
        end
        S_CLOSE: begin
          if (can_emit) begin
            res <= '{kind: meshb_pkg::KIND_CLOSE, global_vertex: '0, local_a: '0,
                     local_b: '0, local_c: '0, meshlet_vertices: vcount,
                     meshlet_indices: icount, last: 1'b0};
            vcount    <= '0;
            icount    <= '0;
            epoch     <= epoch + 1'b1;
            if (epoch == '1) begin
              wipe_resume <= 1'b1;
              state       <= S_WIPE;
            end else begin
              state <= S_VERT;
            end
          end
        end
        S_VERT: begin
          if (step_ok) begin
            if (used[vi]) begin
              loc[vi] <= slot[vi];
            end else if (dup_hit) begin
              loc[vi] <= dup_loc;
            end else begin
              loc[vi] <= vcount;
              vcount  <= vcount + 1'b1;
              res <= '{kind: meshb_pkg::KIND_VERTEX, global_vertex: cur_v[vi],
                       local_a: '0, local_b: '0, local_c: '0, meshlet_vertices: '0,
                       meshlet_indices: '0, last: 1'b0};
            end
            if (vi == 2'd2) begin
              state <= S_TRI;
            end else begin
              vi <= vi + 1'b1;
            end
          end
        end
        S_TRI: begin
          if (can_emit) begin
            res <= '{kind: meshb_pkg::KIND_TRIANGLE, global_vertex: '0,
                     local_a: loc[0], local_b: loc[1], local_c: loc[2],
                     meshlet_vertices: '0, meshlet_indices: '0, last: 1'b1};
            icount    <= icount + meshb_pkg::TRI_INDICES;
            state     <= S_IDLE;
          end
        end
        S_FIN: begin
          if (icount == '0) begin
            state <= S_IDLE;
          end else if (can_emit) begin
            res <= '{kind: meshb_pkg::KIND_CLOSE, global_vertex: '0, local_a: '0,
                     local_b: '0, local_c: '0, meshlet_vertices: vcount,
                     meshlet_indices: icount, last: 1'b1};
            vcount    <= '0;
            icount    <= '0;
            epoch     <= epoch + 1'b1;
            if (epoch == '1) begin
              wipe_resume <= 1'b0;
              state       <= S_WIPE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/meshlet_builder_top.sv =====
// An add word passes through the three serial reads of the single-read-port slot RAM, an
// evaluation step, an optional close step, the one-vertex-per-cycle step sequencer (held
// while a new vertex cannot be emitted) and the triangle step, a finish word through the finish
// step alone; a low m_tready stretches any result cycle. Synchronous reset clears the control
// state and sweeps all MAX_VERTICES slot RAM entries with s_tready low; the same sweep holds up
// the back end after every 255th close.
module meshlet_builder_top #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // vertex_a, vertex_b, vertex_c, zero fill
  input  logic [0:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // global_vertex, local_a, local_b, local_c,
                                 // meshlet_vertices, meshlet_indices, zero fill
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]         vertex_limit;
  logic [7:0]         index_limit;
  meshb_pkg::job_t    job;
  logic               job_valid;
  logic               job_ready;
  meshb_pkg::result_t res;
  logic               init_busy;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == meshb_pkg::REG_INDEX_LIMIT) ? {24'd0, index_limit}
                                                           : {24'd0, vertex_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_limit <= meshb_pkg::VERTEX_LIMIT_RESET;
      index_limit  <= meshb_pkg::INDEX_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == meshb_pkg::REG_VERTEX_LIMIT) begin
        vertex_limit <= pwdata[7:0];
      end else begin
        index_limit <= pwdata[7:0];
      end
    end
  end

  meshb_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (meshb_pkg::cmd_t'(s_tuser[0])),
    .in_va    (s_tdata[11:0]),
    .in_vb    (s_tdata[23:12]),
    .in_vc    (s_tdata[35:24]),
    .init_busy(init_busy),
    .job      (job),
    .job_valid(job_valid),
    .job_ready(job_ready)
  );

  meshb_back #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (job),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .vertex_limit(vertex_limit),
    .index_limit (index_limit),
    .res         (res),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .init_busy   (init_busy)
  );

  assign m_tdata = {4'd0, res.meshlet_indices, res.meshlet_vertices, res.local_c,
                    res.local_b, res.local_a, res.global_vertex};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

// ===== design/meshb_checker.sv =====
module meshb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // The slot RAM is swept straight after reset, so no word may be taken then.
  assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted during the slot table sweep");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
    else $error("stalled result word changed");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == meshb_pkg::KIND_TRIANGLE) |-> m_tlast)
    else $error("triangle word not marked last");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == meshb_pkg::KIND_VERTEX) |-> !m_tlast && (m_tdata[55:12] == '0))
    else $error("malformed vertex word");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == meshb_pkg::KIND_CLOSE) |-> (m_tdata[35:0] == '0) &&
    (m_tdata[51:44] != '0))
    else $error("malformed close word");

endmodule

bind meshlet_builder_top meshb_checker u_meshb_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
